>>> design/bbss_pkg.sv
// Package for the branch-and-bound subset selector.
// Types, codes, widths and helpers shared by controller, datapath and checker.
// No dependencies.
package bbss_pkg;

    localparam int POOL_DEPTH = 32;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam int EFF_W   = 50;
    localparam int FEE_W   = 40;
    localparam int FACE_W  = 50;
    localparam int TAG_W   = 16;
    localparam int TRY_W   = 20;
    localparam int GOAL_W  = 51;
    localparam int UPPER_W = 52;
    localparam int SUM_W   = 56;
    localparam int WASTE_W = 58;
    localparam int OUTW_W  = 57;
    localparam int CFGD_W  = 50;
    localparam int CFGI_W  = 2;

    localparam logic [TRY_W-1:0]   TRIES_AT_RESET = TRY_W'(100000);
    localparam logic [WASTE_W-1:0] WASTE_MAX      = {1'b0, {(WASTE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [CFGI_W-1:0] {
        CFG_TARGET  = 2'd0,
        CFG_CHANGE  = 2'd1,
        CFG_FEES    = 2'd2,
        CFG_TRIES   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RD_IDX      = 2'd0,
        RD_DEPTH    = 2'd1,
        RD_DEPTH_M1 = 2'd2
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_SUM_CHK,
        S_STEP,
        S_FWD_RDP,
        S_FWD_RDC,
        S_FWD_APPLY,
        S_BACK_CHK,
        S_BACK_APPLY,
        S_TOT_RD,
        S_TOT_ACC,
        S_OUT_RD,
        S_OUT_SET,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic [EFF_W-1:0]  eff;
        logic [FEE_W-1:0]  fee;
        logic [FEE_W-1:0]  lfee;
        logic [FACE_W-1:0] face;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    init;
        logic    sum_acc;
        logic    step;
        logic    fwd_cap;
        logic    fwd_apply;
        logic    back_apply;
        logic    tot_acc;
        logic    out_set;
        logic    out_empty;
        logic    idx_clr;
        logic    idx_inc;
        rd_sel_t rd_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic idx_last;
        logic rem_lt_goal;
        logic tries_done;
        logic step_stop;
        logic step_back;
        logic depth_zero;
        logic dm1_bit;
        logic out_fire;
        logic out_last;
    } dp_status_t;

    // Current-rate fee minus long-term fee, both zero-extended to waste width; signed result
    function automatic logic signed [WASTE_W-1:0] excess_fee(input entry_t e);
        return $signed({{(WASTE_W-FEE_W){1'b0}}, e.fee})
             - $signed({{(WASTE_W-FEE_W){1'b0}}, e.lfee});
    endfunction

endpackage

>>> design/bbss_ctrl.sv
// Controller of the branch-and-bound subset selector.
// Sequences load, sum, search, total and result passes; uses bbss_pkg.
module bbss_ctrl import bbss_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  op_t        op,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   in_fire;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && op == OP_RUN) begin
                    state_next = st.count_zero ? S_OUT_WAIT : S_SUM_RD;
                end
            end
            S_SUM_RD:     state_next = S_SUM_ACC;
            S_SUM_ACC:    state_next = st.idx_last ? S_SUM_CHK : S_SUM_RD;
            S_SUM_CHK:    state_next = st.rem_lt_goal ? S_TOT_RD : S_STEP;
            S_STEP: begin
                if (st.tries_done || st.step_stop) begin
                    state_next = S_TOT_RD;
                end else if (st.step_back) begin
                    state_next = S_BACK_CHK;
                end else begin
                    state_next = S_FWD_RDP;
                end
            end
            S_FWD_RDP:    state_next = S_FWD_RDC;
            S_FWD_RDC:    state_next = S_FWD_APPLY;
            S_FWD_APPLY:  state_next = S_STEP;
            S_BACK_CHK:   state_next = st.depth_zero ? S_TOT_RD : S_BACK_APPLY;
            S_BACK_APPLY: state_next = st.dm1_bit ? S_STEP : S_BACK_CHK;
            S_TOT_RD:     state_next = S_TOT_ACC;
            S_TOT_ACC:    state_next = st.idx_last ? S_OUT_RD : S_TOT_RD;
            S_OUT_RD:     state_next = S_OUT_SET;
            S_OUT_SET:    state_next = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (st.out_fire) begin
                    state_next = st.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    case (op)
                        OP_LOAD:  cmd.load  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_RUN: begin
                            cmd.init      = !st.count_zero;
                            cmd.out_empty = st.count_zero;
                        end
                        default: ;
                    endcase
                end
            end
            S_SUM_ACC: begin
                cmd.sum_acc = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_SUM_CHK:    cmd.idx_clr = 1'b1;
            S_STEP: begin
                cmd.step    = !st.tries_done;
                cmd.idx_clr = st.tries_done || st.step_stop;
            end
            S_FWD_RDP:    cmd.rd_sel = RD_DEPTH_M1;
            S_FWD_RDC: begin
                cmd.fwd_cap = 1'b1;
                cmd.rd_sel  = RD_DEPTH;
            end
            S_FWD_APPLY:  cmd.fwd_apply = 1'b1;
            S_BACK_CHK: begin
                cmd.rd_sel  = RD_DEPTH_M1;
                cmd.idx_clr = st.depth_zero;
            end
            S_BACK_APPLY: cmd.back_apply = 1'b1;
            S_TOT_ACC: begin
                cmd.tot_acc = 1'b1;
                cmd.idx_clr = st.idx_last;
                cmd.idx_inc = !st.idx_last;
            end
            S_OUT_SET:    cmd.out_set = 1'b1;
            S_OUT_WAIT:   cmd.idx_inc = st.out_fire;
            default: ;
        endcase
    end

endmodule

>>> design/bbss_datapath.sv
// Datapath of the branch-and-bound subset selector.
// Sorted candidate table, search registers, config registers, result register.
// Uses bbss_pkg.
module bbss_datapath import bbss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        st,
    input  entry_t            in_entry,
    input  logic              cfg_fire,
    input  cfg_idx_t          cfg_index,
    input  logic [CFGD_W-1:0] cfg_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_found,
    output logic              out_selected,
    output logic [TAG_W-1:0]  out_tag,
    output logic [SUM_W-1:0]  out_total,
    output logic [OUTW_W-1:0] out_waste,
    output logic              out_last
);

    // Configuration
    logic [EFF_W-1:0] target_reg;
    logic [FEE_W-1:0] change_reg;
    logic [FEE_W-1:0] fees_reg;
    logic [TRY_W-1:0] tries_max_reg;

    // Table
    entry_t           tab_reg [POOL_DEPTH];
    logic [CNT_W-1:0] count_reg;
    entry_t           rd_reg;

    // Search
    logic [POOL_DEPTH-1:0]     path_reg, best_reg;
    logic [CNT_W-1:0]          depth_reg, idx_reg;
    logic [SUM_W-1:0]          rv_reg, rem_reg, total_reg;
    logic signed [WASTE_W-1:0] rw_reg, lowest_reg;
    logic [TRY_W-1:0]          try_reg;
    logic                      found_reg, ex0_pos_reg;
    logic [EFF_W-1:0]          prev_eff_reg;
    logic [FEE_W-1:0]          prev_fee_reg;
    logic [GOAL_W-1:0]         goal_reg;
    logic [UPPER_W-1:0]        upper_reg;

    logic                      out_valid_reg, out_found_reg, out_sel_reg, out_last_reg;
    logic [TAG_W-1:0]          out_tag_reg;
    logic [SUM_W-1:0]          out_total_reg;
    logic [OUTW_W-1:0]         out_waste_reg;

    logic [POOL_DEPTH-1:0]     ge_vec;
    logic [CNT_W-1:0]          ins_pos;
    logic [IDX_W-1:0]          rd_addr, d_idx, dm1_idx, i_idx;
    logic [SUM_W:0]            reach;
    logic [SUM_W-1:0]          over_goal;
    logic signed [WASTE_W-1:0] w_cand;
    logic                      c_back, c_ge, c_hit;

    assign d_idx   = depth_reg[IDX_W-1:0];
    assign dm1_idx = IDX_W'(depth_reg - CNT_W'(1));
    assign i_idx   = idx_reg[IDX_W-1:0];

    // Insert position: entries at or above the new value, a prefix of the table
    always_comb begin
        for (int k = 0; k < POOL_DEPTH; k++) begin
            ge_vec[k] = (CNT_W'(k) < count_reg) && (tab_reg[k].eff >= in_entry.eff);
        end
        ins_pos = CNT_W'($countones(ge_vec));
    end

    // Read address
    always_comb begin
        case (cmd.rd_sel)
            RD_DEPTH:    rd_addr = d_idx;
            RD_DEPTH_M1: rd_addr = dm1_idx;
            default:     rd_addr = i_idx;
        endcase
    end

    // Search step evaluation
    always_comb begin
        reach     = {1'b0, rv_reg} + {1'b0, rem_reg};
        over_goal = rv_reg - SUM_W'(goal_reg);
        w_cand    = rw_reg + $signed({{(WASTE_W-SUM_W){1'b0}}, over_goal});
        c_back    = (reach < (SUM_W+1)'(goal_reg)) || (rv_reg > SUM_W'(upper_reg))
                 || ((rw_reg > lowest_reg) && ex0_pos_reg);
        c_ge      = rv_reg >= SUM_W'(goal_reg);
        c_hit     = !c_back && c_ge && (w_cand <= lowest_reg);
    end

    always_comb begin
        st.count_zero  = (count_reg == '0);
        st.idx_last    = (idx_reg + CNT_W'(1) == count_reg);
        st.rem_lt_goal = rem_reg < SUM_W'(goal_reg);
        st.tries_done  = try_reg >= tries_max_reg;
        st.step_stop   = c_hit && (w_cand == '0);
        st.step_back   = c_back || c_ge || (depth_reg >= count_reg);
        st.depth_zero  = (depth_reg == '0);
        st.dm1_bit     = path_reg[dm1_idx];
        st.out_fire    = out_valid_reg && out_ready;
        st.out_last    = out_last_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg    <= '0;
            change_reg    <= '0;
            fees_reg      <= '0;
            tries_max_reg <= TRIES_AT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    CFG_TARGET: target_reg    <= cfg_data;
                    CFG_CHANGE: change_reg    <= cfg_data[FEE_W-1:0];
                    CFG_FEES:   fees_reg      <= cfg_data[FEE_W-1:0];
                    CFG_TRIES:  tries_max_reg <= cfg_data[TRY_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clear) begin
                count_reg <= '0;
            end else if (cmd.load && count_reg < CNT_W'(POOL_DEPTH)) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_set || cmd.out_empty) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Table insert: shift the tail down one place
    always_ff @(posedge aclk) begin
        if (cmd.load && count_reg < CNT_W'(POOL_DEPTH)) begin
            for (int k = 0; k < POOL_DEPTH; k++) begin
                if (CNT_W'(k) == ins_pos) begin
                    tab_reg[k] <= in_entry;
                end else if (k > 0 && CNT_W'(k) > ins_pos && CNT_W'(k) <= count_reg) begin
                    tab_reg[k] <= tab_reg[(k > 0) ? k - 1 : 0];
                end
            end
        end
        rd_reg <= tab_reg[rd_addr];
    end

    // Search registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_reg   <= '0;
            best_reg   <= '0;
            depth_reg  <= '0;
            idx_reg    <= '0;
            rv_reg     <= '0;
            rem_reg    <= '0;
            rw_reg     <= '0;
            lowest_reg <= WASTE_MAX;
            try_reg    <= '0;
            found_reg  <= 1'b0;
        end else begin
            if (cmd.init) begin
                path_reg   <= '0;
                best_reg   <= '0;
                depth_reg  <= '0;
                rv_reg     <= '0;
                rem_reg    <= '0;
                rw_reg     <= '0;
                lowest_reg <= WASTE_MAX;
                try_reg    <= '0;
                found_reg  <= 1'b0;
                goal_reg   <= GOAL_W'(target_reg) + GOAL_W'(fees_reg);
                upper_reg  <= UPPER_W'(target_reg) + UPPER_W'(fees_reg)
                            + UPPER_W'(change_reg);
                total_reg  <= '0;
            end
            if (cmd.sum_acc) begin
                rem_reg <= rem_reg + SUM_W'(rd_reg.eff);
                if (idx_reg == '0) begin
                    ex0_pos_reg <= rd_reg.fee > rd_reg.lfee;
                end
            end
            if (cmd.step) begin
                try_reg <= try_reg + TRY_W'(1);
                if (c_hit) begin
                    best_reg   <= path_reg;
                    lowest_reg <= w_cand;
                    found_reg  <= 1'b1;
                end
            end
            if (cmd.fwd_cap) begin
                prev_eff_reg <= rd_reg.eff;
                prev_fee_reg <= rd_reg.fee;
            end
            // Advance: include entry unless it repeats an omitted predecessor
            if (cmd.fwd_apply) begin
                rem_reg <= rem_reg - SUM_W'(rd_reg.eff);
                if (depth_reg != '0 && !path_reg[dm1_idx] && rd_reg.eff == prev_eff_reg
                        && rd_reg.fee == prev_fee_reg) begin
                    path_reg[d_idx] <= 1'b0;
                end else begin
                    path_reg[d_idx] <= 1'b1;
                    rv_reg          <= rv_reg + SUM_W'(rd_reg.eff);
                    rw_reg          <= rw_reg + excess_fee(rd_reg);
                end
                depth_reg <= depth_reg + CNT_W'(1);
            end
            // Backtrack: pop omitted entries, then turn the last inclusion into omission
            if (cmd.back_apply) begin
                if (!path_reg[dm1_idx]) begin
                    depth_reg <= depth_reg - CNT_W'(1);
                    rem_reg   <= rem_reg + SUM_W'(rd_reg.eff);
                end else begin
                    path_reg[dm1_idx] <= 1'b0;
                    rv_reg            <= rv_reg - SUM_W'(rd_reg.eff);
                    rw_reg            <= rw_reg - excess_fee(rd_reg);
                end
            end
            if (cmd.tot_acc && found_reg && best_reg[i_idx]) begin
                total_reg <= total_reg + SUM_W'(rd_reg.face);
            end
            if (cmd.idx_clr || cmd.init) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_empty) begin
            out_found_reg <= 1'b0;
            out_sel_reg   <= 1'b0;
            out_tag_reg   <= '0;
            out_total_reg <= '0;
            out_waste_reg <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.out_set) begin
            out_found_reg <= found_reg;
            out_sel_reg   <= found_reg && best_reg[i_idx];
            out_tag_reg   <= rd_reg.tag;
            out_total_reg <= st.idx_last ? total_reg : '0;
            out_waste_reg <= found_reg ? lowest_reg[OUTW_W-1:0] : '0;
            out_last_reg  <= st.idx_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = out_found_reg;
    assign out_selected = out_sel_reg;
    assign out_tag      = out_tag_reg;
    assign out_total    = out_total_reg;
    assign out_waste    = out_waste_reg;
    assign out_last     = out_last_reg;

endmodule

>>> design/branch_bound_subset_select.sv
// Channel  | Signals                                 | Carries
// s_       | s_tvalid s_tready s_tdata s_tuser       | op, candidate fields
// m_       | m_tvalid m_tready m_tdata m_tlast       | one result per entry
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data  | register writes
//
// Load and clear are taken while idle and do not leave it; the table insert
// shifts the tail as one register write. A run sums and checks the table,
// steps the search forward (read previous, read current, apply) or back (pop
// omitted entries one table read at a time, then flip), totals the face
// values, then sends each result (read, set, wait) subject to output stalls.
// Reset: synchronous, active low; the table content is undefined after it.
// A stalled result holds the block; no item is taken until the last is gone.
// Top level of the branch-and-bound subset selector; uses bbss_pkg,
// bbss_ctrl and bbss_datapath.
module branch_bound_subset_select import bbss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // eff[49:0] fee[89:50] long_fee[129:90] face[179:130] tag[195:180]
    input  logic [199:0]      s_tdata,
    // op[1:0]
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // found[0] selected[1] entry_tag[17:2] total_value[73:18] waste[130:74]
    output logic [135:0]      m_tdata,
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFGD_W-1:0] cfg_data
);

    dp_cmd_t           cmd;
    dp_status_t        st;
    entry_t            in_entry;
    logic              o_found, o_sel;
    logic [TAG_W-1:0]  o_tag;
    logic [SUM_W-1:0]  o_total;
    logic [OUTW_W-1:0] o_waste;

    assign cfg_ready = 1'b1;

    // Unpack candidate
    assign in_entry.eff  = s_tdata[49:0];
    assign in_entry.fee  = s_tdata[89:50];
    assign in_entry.lfee = s_tdata[129:90];
    assign in_entry.face = s_tdata[179:130];
    assign in_entry.tag  = s_tdata[195:180];

    bbss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op_t'(s_tuser)),
        .st       (st),
        .cmd      (cmd)
    );

    bbss_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .st           (st),
        .in_entry     (in_entry),
        .cfg_fire     (cfg_valid && cfg_ready),
        .cfg_index    (cfg_idx_t'(cfg_index)),
        .cfg_data     (cfg_data),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_found    (o_found),
        .out_selected (o_sel),
        .out_tag      (o_tag),
        .out_total    (o_total),
        .out_waste    (o_waste),
        .out_last     (m_tlast)
    );

    // Pack result
    assign m_tdata = {5'b0, o_waste, o_total, o_tag, o_sel, o_found};

endmodule

>>> design/bbss_checker.sv
// Port-level checker for the branch-and-bound subset selector.
// Watches the top-level ports only; uses bbss_pkg; bound to the top level.
module bbss_checker import bbss_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         m_tlast
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Take no item while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");

    // Drop valid after the final result of a run
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result after the final one");

    // Load and clear items give no result
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_RUN) |=> !m_tvalid)
        else $error("result from a load or clear");

endmodule

bind branch_bound_subset_select bbss_checker u_bbss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
